// ===== hdl/wfha_pkg.sv =====
// wfha_pkg: shared types, codes and widths for the worst-fit hole allocator
// no dependencies; used by every file under hdl

package wfha_pkg;

    localparam int ADDR_W        = 24;
    localparam int SIZE_W        = 25;
    localparam int FREE_OUT_W    = 29;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 2;
    localparam int S_TDATA_W     = 56;
    localparam int M_TDATA_W     = 56;
    localparam int MAX_HOLES_DEF = 16;

    localparam logic [SIZE_W-1:0]     MEM_SIZE_RESET = 25'd16777216;
    localparam logic [FREE_OUT_W-1:0] FREE_OUT_MAX   = '1;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXCEED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
    } hole_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [ADDR_W-1:0]     addr;
        logic [FREE_OUT_W-1:0] free_total;
    } res_t;

endpackage

// ===== hdl/wfha_mem.sv =====
// wfha_mem: hole table, one write port and one registered read port
// depends on wfha_pkg for the entry type

module wfha_mem #(
    parameter int DEPTH = wfha_pkg::MAX_HOLES_DEF,
    parameter int IDX_W = 4
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  wfha_pkg::hole_t      wr_data,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output wfha_pkg::hole_t      rd_data
);

    wfha_pkg::hole_t mem [DEPTH];
    wfha_pkg::hole_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/wfha_ctrl.sv =====
// wfha_ctrl: sequencer for clear, add and worst-fit allocate over the hole table
// depends on wfha_pkg; drives the wfha_mem ports

module wfha_ctrl #(
    parameter int MAX_HOLES = wfha_pkg::MAX_HOLES_DEF,
    parameter int IDX_W     = 4,
    parameter int CNT_W     = 5,
    parameter int FREE_W    = 30
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [wfha_pkg::OP_W-1:0]      in_op,
    input  logic [wfha_pkg::ADDR_W-1:0]    in_start,
    input  logic [wfha_pkg::SIZE_W-1:0]    in_amount,
    input  logic [wfha_pkg::SIZE_W-1:0]    memory_size,
    output logic                           mem_wr_en,
    output logic [IDX_W-1:0]               mem_wr_addr,
    output wfha_pkg::hole_t                mem_wr_data,
    output logic                           mem_rd_en,
    output logic [IDX_W-1:0]               mem_rd_addr,
    input  wfha_pkg::hole_t                mem_rd_data,
    output logic                           res_valid,
    input  logic                           res_ready,
    output wfha_pkg::res_t                 res
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_HOLES);

    logic [2:0]                      state_reg, state_next;
    logic [wfha_pkg::OP_W-1:0]       op_reg, op_next;
    logic [wfha_pkg::ADDR_W-1:0]     start_reg, start_next;
    logic [wfha_pkg::SIZE_W-1:0]     amount_reg, amount_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [FREE_W-1:0]               free_reg, free_next;
    logic [CNT_W-1:0]                scan_reg, scan_next;
    logic                            cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]                cmp_idx_reg, cmp_idx_next;
    logic                            best_any_reg, best_any_next;
    logic [IDX_W-1:0]                best_idx_reg, best_idx_next;
    wfha_pkg::hole_t                 best_reg, best_next;
    wfha_pkg::res_t                  res_reg, res_next;

    logic [wfha_pkg::SIZE_W:0]       hole_end;
    logic                            exceed;
    logic [FREE_W-1:0]               free_after;
    logic [wfha_pkg::FREE_OUT_W-1:0] free_sat;

    assign hole_end = {2'b00, start_reg} + {1'b0, amount_reg};
    assign exceed   = hole_end > {1'b0, memory_size};

    // saturated view of the running free total
    always_comb
    begin
        if (free_after > FREE_W'(wfha_pkg::FREE_OUT_MAX))
        begin
            free_sat = wfha_pkg::FREE_OUT_MAX;
        end
        else
        begin
            free_sat = free_after[wfha_pkg::FREE_OUT_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        start_next     = start_reg;
        amount_next    = amount_reg;
        count_next     = count_reg;
        free_next      = free_reg;
        scan_next      = scan_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        best_any_next  = best_any_reg;
        best_idx_next  = best_idx_reg;
        best_next      = best_reg;
        res_next       = res_reg;
        free_after     = free_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = count_reg[IDX_W-1:0];
        mem_wr_data    = '{start: start_reg, size: amount_reg};
        mem_rd_en      = 1'b0;
        mem_rd_addr    = scan_reg[IDX_W-1:0];

        // running maximum, strict compare keeps the lowest index on ties
        if (cmp_valid_reg)
        begin
            if (!best_any_reg || (mem_rd_data.size > best_reg.size))
            begin
                best_any_next = 1'b1;
                best_idx_next = cmp_idx_reg;
                best_next     = mem_rd_data;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = in_op;
                    start_next  = in_start;
                    amount_next = in_amount;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_next.status = wfha_pkg::ST_OK;
                res_next.addr   = '0;
                state_next      = S_RESULT;
                case (op_reg)
                    wfha_pkg::OP_CLEAR:
                    begin
                        count_next = '0;
                        free_next  = '0;
                        free_after = '0;
                    end
                    wfha_pkg::OP_ADD:
                    begin
                        if (exceed)
                        begin
                            res_next.status = wfha_pkg::ST_EXCEED;
                        end
                        else if (count_reg == CNT_FULL)
                        begin
                            res_next.status = wfha_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_wr_en  = 1'b1;
                            count_next = count_reg + 1'b1;
                            free_after = free_reg + FREE_W'(amount_reg);
                            free_next  = free_after;
                        end
                    end
                    wfha_pkg::OP_ALLOC:
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = wfha_pkg::ST_NOFIT;
                        end
                        else
                        begin
                            scan_next     = '0;
                            best_any_next = 1'b0;
                            state_next    = S_SCAN;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                res_next.free_total = free_sat;
            end
            S_SCAN:
            begin
                mem_rd_en      = 1'b1;
                cmp_valid_next = 1'b1;
                cmp_idx_next   = scan_reg[IDX_W-1:0];
                scan_next      = scan_reg + 1'b1;
                if (scan_next == count_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                res_next.addr   = '0;
                res_next.status = wfha_pkg::ST_OK;
                if (best_reg.size < amount_reg)
                begin
                    res_next.status = wfha_pkg::ST_NOFIT;
                end
                else
                begin
                    res_next.addr     = best_reg.start;
                    mem_wr_en         = 1'b1;
                    mem_wr_addr       = best_idx_reg;
                    mem_wr_data.start = best_reg.start + amount_reg[wfha_pkg::ADDR_W-1:0];
                    mem_wr_data.size  = best_reg.size - amount_reg;
                    free_after        = free_reg - FREE_W'(amount_reg);
                    free_next         = free_after;
                end
                res_next.free_total = free_sat;
                state_next          = S_RESULT;
            end
            S_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            free_reg      <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            free_reg      <= free_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        start_reg    <= start_next;
        amount_reg   <= amount_next;
        scan_reg     <= scan_next;
        cmp_idx_reg  <= cmp_idx_next;
        best_any_reg <= best_any_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        res_reg      <= res_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESULT);
    assign res       = res_reg;

endmodule

// ===== hdl/worst_fit_hole_allocator.sv =====
// worst_fit_hole_allocator: top level with config register and output register
// depends on wfha_pkg, wfha_mem and wfha_ctrl
//
// channel  dir  handshake                 payload
// s        in   s_tvalid / s_tready       tuser: operation; tdata: hole_start, amount
// m        out  m_tvalid / m_tready       tuser: status; tdata: alloc_address, free_total
// cfg      in   cfg_valid / cfg_ready     cfg_data: memory_size
//
// clear, add, the unused code and allocate on an empty table go from idle through exec
// to result, then back to idle once the output register takes the result
// allocate on a nonempty table goes on from exec through scan, drain and decide:
// the table's single read port is swept one hole per cycle, then the chosen hole
// is written back
// reset clears the hole count, free total and handshake state; table contents stay
// a waiting result sits in the output register and holds only the sequencer

module worst_fit_hole_allocator #(
    parameter int MAX_HOLES = wfha_pkg::MAX_HOLES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [wfha_pkg::S_TDATA_W-1:0]    s_tdata,   // hole_start, amount, zero pad
    input  logic [wfha_pkg::OP_W-1:0]         s_tuser,   // operation
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [wfha_pkg::M_TDATA_W-1:0]    m_tdata,   // alloc_address, free_total, zero pad
    output logic [wfha_pkg::STATUS_W-1:0]     m_tuser,   // status
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wfha_pkg::SIZE_W-1:0]       cfg_data   // memory_size
);

    localparam int IDX_W  = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
    localparam int CNT_W  = $clog2(MAX_HOLES + 1);
    localparam int FSUM_W = wfha_pkg::SIZE_W + CNT_W;
    localparam int FREE_W = (FSUM_W > wfha_pkg::FREE_OUT_W + 1) ? FSUM_W
                                                                : wfha_pkg::FREE_OUT_W + 1;
    localparam int M_PAD_W = wfha_pkg::M_TDATA_W - wfha_pkg::ADDR_W - wfha_pkg::FREE_OUT_W;

    logic [wfha_pkg::SIZE_W-1:0] mem_size_reg;
    logic                        m_valid_reg, m_valid_next;
    wfha_pkg::res_t              m_res_reg;

    logic                        in_ready;
    logic                        mem_wr_en;
    logic [IDX_W-1:0]            mem_wr_addr;
    wfha_pkg::hole_t             mem_wr_data;
    logic                        mem_rd_en;
    logic [IDX_W-1:0]            mem_rd_addr;
    wfha_pkg::hole_t             mem_rd_data;
    logic                        res_valid;
    logic                        res_ready;
    wfha_pkg::res_t              res;

    assign cfg_ready = 1'b1;
    assign s_tready  = in_ready;
    assign res_ready = !m_valid_reg || m_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_size_reg <= wfha_pkg::MEM_SIZE_RESET;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mem_size_reg <= cfg_data;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_res_reg.free_total, m_res_reg.addr};

    wfha_mem #(
        .DEPTH (MAX_HOLES),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    wfha_ctrl #(
        .MAX_HOLES (MAX_HOLES),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W),
        .FREE_W    (FREE_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (in_ready),
        .in_op       (s_tuser),
        .in_start    (s_tdata[wfha_pkg::ADDR_W-1:0]),
        .in_amount   (s_tdata[wfha_pkg::ADDR_W+wfha_pkg::SIZE_W-1:wfha_pkg::ADDR_W]),
        .memory_size (mem_size_reg),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

endmodule

// ===== hdl/wfha_checker.sv =====
// wfha_checker: port-level checks for worst_fit_hole_allocator, bound to the top
// depends on wfha_pkg for widths and status codes

module wfha_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [wfha_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic [wfha_pkg::STATUS_W-1:0]     m_tuser
);

    // one item at a time: input closes right after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready after a transfer");

    // no address is granted on a failed result
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != wfha_pkg::ST_OK)) |-> (m_tdata[wfha_pkg::ADDR_W-1:0] == '0))
        else $error("address on failed result");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind worst_fit_hole_allocator wfha_checker u_wfha_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== dv/testbench.sv =====
// testbench: self-checking stream test of worst_fit_hole_allocator
// depends on wfha_pkg and the rtl under hdl; predicts each result from its own hole table
// directed table first, then random phases under several memory sizes and idle patterns

module testbench;

    import wfha_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE    = 2'd3;
    localparam int              PHASE_ITEMS = 250;
    localparam int              HOLD_CYCLES = 300;
    localparam int              TAIL_CYCLES = 30;
    localparam int              CYCLE_LIMIT = 400000;
    localparam bit [5:0]        TX_IDLE_PLAN = 6'b110111;
    localparam bit [5:0]        RX_IDLE_PLAN = 6'b110011;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] amount;
        bit                fixed;
        res_t              fixed_res;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0]      s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [SIZE_W-1:0]    cfg_data = '0;

    logic [ADDR_W-1:0]    hole_base [MAX_HOLES_DEF];
    logic [SIZE_W-1:0]    hole_len [MAX_HOLES_DEF];
    int                   hole_cnt = 0;
    longint unsigned      free_acc = 0;
    logic [SIZE_W-1:0]    mem_limit = MEM_SIZE_RESET;

    res_t                 pending_q [$];
    stim_row_t            stim_tab [$];
    int                   mismatches = 0;
    int                   cycle_cnt = 0;
    bit                   tx_idle = 1'b1;
    bit                   rx_idle = 1'b1;
    bit                   hold_req = 1'b0;
    bit                   hold_on = 1'b0;

    worst_fit_hole_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic res_t apply_hole_op(input logic [OP_W-1:0] op,
                                           input logic [ADDR_W-1:0] st,
                                           input logic [SIZE_W-1:0] amt);
        res_t r;
        int   best;
        r = '0;
        best = -1;
        case (op)
            OP_CLEAR:
            begin
                hole_cnt = 0;
                free_acc = 0;
            end
            OP_ADD:
            begin
                if (64'(st) + 64'(amt) > 64'(mem_limit))
                    r.status = ST_EXCEED;
                else if (hole_cnt >= MAX_HOLES_DEF)
                    r.status = ST_FULL;
                else
                begin
                    hole_base[hole_cnt] = st;
                    hole_len[hole_cnt] = amt;
                    hole_cnt = hole_cnt + 1;
                    free_acc = free_acc + amt;
                end
            end
            OP_ALLOC:
            begin
                for (int j = 0; j < hole_cnt; j++)
                    if (best < 0 || hole_len[j] > hole_len[best])
                        best = j;
                if (best < 0 || hole_len[best] < amt)
                    r.status = ST_NOFIT;
                else
                begin
                    r.addr = hole_base[best];
                    hole_base[best] = hole_base[best] + amt[ADDR_W-1:0];
                    hole_len[best] = hole_len[best] - amt;
                    free_acc = free_acc - amt;
                end
            end
            default: ;
        endcase
        r.free_total = (free_acc > 64'(FREE_OUT_MAX)) ? FREE_OUT_MAX
                                                      : free_acc[FREE_OUT_W-1:0];
        return r;
    endfunction

    function automatic logic [SIZE_W-1:0] widest_hole();
        logic [SIZE_W-1:0] w;
        w = '0;
        for (int j = 0; j < hole_cnt; j++)
            if (hole_len[j] > w)
                w = hole_len[j];
        return w;
    endfunction

    function automatic res_t mk_res(input logic [STATUS_W-1:0] st,
                                    input logic [ADDR_W-1:0] a,
                                    input logic [FREE_OUT_W-1:0] f);
        res_t r;
        r.status = st;
        r.addr = a;
        r.free_total = f;
        return r;
    endfunction

    task automatic add_row(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] st,
                           input logic [SIZE_W-1:0] amt, input bit fixed, input res_t fr);
        stim_row_t row;
        row.op = op;
        row.start = st;
        row.amount = amt;
        row.fixed = fixed;
        row.fixed_res = fr;
        stim_tab.push_back(row);
    endtask

    // memory size is at its reset value for the whole table
    task automatic build_stim_table();
        res_t none;
        none = '0;
        add_row(OP_ALLOC, 24'd0, 25'd5, 1, mk_res(ST_NOFIT, 24'd0, 29'd0));
        add_row(OP_SPARE, 24'hFFFFFF, 25'h1FFFFFF, 1, mk_res(ST_OK, 24'd0, 29'd0));
        add_row(OP_ADD, 24'hFFFFFF, 25'd2, 1, mk_res(ST_EXCEED, 24'd0, 29'd0));
        add_row(OP_ADD, 24'd0, 25'h1FFFFFF, 1, mk_res(ST_EXCEED, 24'd0, 29'd0));
        add_row(OP_ADD, 24'd0, 25'd16777216, 1, mk_res(ST_OK, 24'd0, 29'd16777216));
        add_row(OP_ALLOC, 24'd0, 25'd0, 1, mk_res(ST_OK, 24'd0, 29'd16777216));
        add_row(OP_ALLOC, 24'd0, 25'd16777216, 1, mk_res(ST_OK, 24'd0, 29'd0));
        add_row(OP_ALLOC, 24'd0, 25'd1, 1, mk_res(ST_NOFIT, 24'd0, 29'd0));
        add_row(OP_CLEAR, 24'd0, 25'd0, 1, mk_res(ST_OK, 24'd0, 29'd0));
        add_row(OP_ADD, 24'hFFFFFF, 25'd0, 1, mk_res(ST_OK, 24'd0, 29'd0));
        // equal sizes so the lowest index must win the tie
        for (int k = 1; k < MAX_HOLES_DEF; k++)
            add_row(OP_ADD, 24'(k * 4096), 25'd1000, 0, none);
        add_row(OP_ADD, 24'd0, 25'd1, 1, mk_res(ST_FULL, 24'd0, 29'd15000));
        add_row(OP_ALLOC, 24'd0, 25'd1000, 0, none);
        add_row(OP_ALLOC, 24'd0, 25'd1001, 1, mk_res(ST_NOFIT, 24'd0, 29'd14000));
        add_row(OP_ALLOC, 24'hFFFFFF, 25'd999, 0, none);
    endtask

    task automatic pick_item(output logic [OP_W-1:0] op, output logic [ADDR_W-1:0] st,
                             output logic [SIZE_W-1:0] amt);
        int unsigned       r;
        int unsigned       lim;
        logic [SIZE_W-1:0] big;
        r = $urandom_range(0, 99);
        st = '0;
        amt = '0;
        if (r < 3)
            op = OP_CLEAR;
        else if (r < 5)
        begin
            op = OP_SPARE;
            st = ADDR_W'($urandom());
            amt = SIZE_W'($urandom());
        end
        else if (r < 50)
        begin
            op = OP_ADD;
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                st = ADDR_W'($urandom());
                amt = SIZE_W'($urandom());
            end
            else
            begin
                amt = SIZE_W'($urandom_range(0, 32'(mem_limit >> 2)));
                lim = 32'(mem_limit - amt);
                st = ADDR_W'($urandom_range(0, (lim > 32'hFFFFFF) ? 32'hFFFFFF : lim));
                // holes that end exactly at the memory end, or one past it
                if (r < 20)
                    amt = mem_limit - st;
                else if (r < 25 && (mem_limit - st) < 25'h1FFFFFF)
                    amt = mem_limit - st + 25'd1;
            end
        end
        else
        begin
            op = OP_ALLOC;
            big = widest_hole();
            r = $urandom_range(0, 99);
            if (r < 10)
                amt = SIZE_W'($urandom());
            else if (r < 20)
                amt = big;
            else if (r < 25)
                amt = big + 25'd1;
            else
                amt = SIZE_W'($urandom_range(0, 32'(big)));
        end
    endtask

    task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] st,
                             input logic [SIZE_W-1:0] amt, input bit fixed,
                             input res_t fixed_res);
        int   gap;
        res_t pred;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {{(S_TDATA_W - ADDR_W - SIZE_W){1'b0}}, amt, st};
        do
            @(posedge clk);
        while (!s_tready);
        pred = apply_hole_op(op, st, amt);
        pending_q.push_back(fixed ? fixed_res : pred);
    endtask

    task automatic stop_input();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_mem_size(input logic [SIZE_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        mem_limit = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_result(input res_t act);
        res_t exp;
        if (pending_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: status %0d addr %0h free %0h",
                         act.status, act.addr, act.free_total);
        end
        else
        begin
            exp = pending_q.pop_front();
            if (exp.status !== act.status || exp.addr !== act.addr
                || exp.free_total !== act.free_total)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected status %0d addr %0h free %0h, got %0d %0h %0h",
                             exp.status, exp.addr, exp.free_total,
                             act.status, act.addr, act.free_total);
            end
        end
    endtask

    initial
    begin : result_sink
        int   stall_left;
        res_t act;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_on || stall_left > 0)
            begin
                m_tready <= 1'b0;
                if (!hold_on)
                    stall_left = stall_left - 1;
            end
            else
                m_tready <= 1'b1;
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                act.status = m_tuser;
                act.addr = m_tdata[ADDR_W-1:0];
                act.free_total = m_tdata[ADDR_W +: FREE_OUT_W];
                check_result(act);
                stall_left = rx_idle ? $urandom_range(0, 9) : 0;
            end
        end
    end

    // long receiver stall so the block backs up into its input
    initial
    begin : sink_hold
        wait (hold_req);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
    end

    initial
    begin : stimulus
        logic [SIZE_W-1:0] mem_plan [6];
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] st;
        logic [SIZE_W-1:0] amt;
        res_t              none;
        none = '0;
        mem_plan[0] = 25'd0;
        mem_plan[1] = 25'd4096;
        mem_plan[2] = 25'h1FFFFFF;
        mem_plan[3] = MEM_SIZE_RESET;
        mem_plan[4] = SIZE_W'($urandom_range(1, 32'h1FFFFFF));
        mem_plan[5] = 25'd1000000;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        build_stim_table();
        foreach (stim_tab[i])
            send_item(stim_tab[i].op, stim_tab[i].start, stim_tab[i].amount,
                      stim_tab[i].fixed, stim_tab[i].fixed_res);
        stop_input();

        for (int ph = 0; ph < 6; ph++)
        begin
            drain_results();
            write_mem_size(mem_plan[ph]);
            tx_idle = TX_IDLE_PLAN[ph];
            rx_idle = RX_IDLE_PLAN[ph];
            if (ph == 1)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick_item(op, st, amt);
                send_item(op, st, amt, 0, none);
            end
            stop_input();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/wfha_pkg.sv
hdl/wfha_mem.sv
hdl/wfha_ctrl.sv
hdl/worst_fit_hole_allocator.sv
hdl/wfha_checker.sv
dv/testbench.sv
